[rtl/sda_pkg.sv]
// ============================================================================
// sda_pkg - shared constants and helpers for the signed dihedral angle block
// Fixed-point formats, angle constants, arctangent table and multiplier
// latency helper.
// ============================================================================
package sda_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int LIMB_W          = 32;  // multiplier limb width
    localparam int ANG_W           = 32;  // angle width, unsigned Q3.29
    localparam int FRAC_BITS       = 29;  // normalized magnitude bound 2^29
    localparam int SH_W            = FRAC_BITS + 1;
    localparam int CORDIC_STEPS    = 30;

    localparam logic [ANG_W-1:0] ANG_PI      = 32'd1686629713;
    localparam logic [ANG_W-1:0] ANG_HALF_PI = 32'd843314857;
    localparam logic [ANG_W-1:0] ANG_TWO_PI  = 32'd3373259426;

    // Latency of sda_mul: one product stage plus a registered adder tree.
    function automatic int mul_latency(input int aw, input int bw);
        int la;
        int lb;
        la = (aw + LIMB_W - 1) / LIMB_W;
        lb = (bw + LIMB_W - 1) / LIMB_W;
        return 1 + $clog2(la * lb);
    endfunction

    // atan(2^-i) in Q3.29, rounded to nearest
    function automatic logic [ANG_W-1:0] atan_entry(input int i);
        logic [ANG_W-1:0] t;
        unique case (i)
            0:       t = 32'd421657428;
            1:       t = 32'd248918915;
            2:       t = 32'd131521918;
            3:       t = 32'd66762579;
            4:       t = 32'd33510843;
            5:       t = 32'd16771758;
            6:       t = 32'd8387925;
            7:       t = 32'd4194219;
            8:       t = 32'd2097141;
            9:       t = 32'd1048575;
            default: t = ANG_W'(64'd1 << (FRAC_BITS - i)); // atan(x) == x here
        endcase
        return t;
    endfunction

    // Bit length of a 32-bit word (index of top one plus one, 0 if zero)
    function automatic logic [5:0] bit_len32(input logic [31:0] v);
        logic [5:0] n;
        n = '0;
        for (int i = 0; i < 32; i++) begin
            if (v[i]) begin
                n = 6'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

[rtl/sda_mul.sv]
// ============================================================================
// sda_mul - pipelined signed multiplier
// Splits both operands into 32-bit limbs, registers the limb products and
// sums them in a registered binary tree.
// ============================================================================
module sda_mul
    import sda_pkg::*;
#(
    parameter int AW = COORD_WIDTH_DEF,
    parameter int BW = COORD_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic                    en,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic signed [AW+BW-1:0] p
);

    localparam int LA     = (AW + LIMB_W - 1) / LIMB_W;
    localparam int LB     = (BW + LIMB_W - 1) / LIMB_W;
    localparam int NP     = LA * LB;
    localparam int LEVELS = $clog2(NP);
    localparam int NPP    = 1 << LEVELS;
    localparam int NN     = 2 * NPP - 1;
    localparam int PW     = AW + BW;
    localparam int AP     = LA * LIMB_W;
    localparam int BP     = LB * LIMB_W;
    localparam int XW     = PW + 2 * LIMB_W + 2;

    logic signed [AP-1:0]         a_pad;
    logic signed [BP-1:0]         b_pad;
    logic signed [LIMB_W:0]       a_limb [LA];
    logic signed [LIMB_W:0]       b_limb [LB];
    logic signed [2*LIMB_W+1:0]   prod   [NP];
    logic signed [XW-1:0]         prod_x [NP];
    logic signed [PW-1:0]         leaf   [NPP];
    logic signed [PW-1:0]         node_reg [NN];

    always_comb begin
        a_pad = AP'(a);
        b_pad = BP'(b);
        // low limbs unsigned, top limb carries the sign
        for (int i = 0; i < LA; i++) begin
            if (i == LA - 1) begin
                a_limb[i] = {a_pad[AP-1], a_pad[i*LIMB_W +: LIMB_W]};
            end else begin
                a_limb[i] = {1'b0, a_pad[i*LIMB_W +: LIMB_W]};
            end
        end
        for (int j = 0; j < LB; j++) begin
            if (j == LB - 1) begin
                b_limb[j] = {b_pad[BP-1], b_pad[j*LIMB_W +: LIMB_W]};
            end else begin
                b_limb[j] = {1'b0, b_pad[j*LIMB_W +: LIMB_W]};
            end
        end
        for (int i = 0; i < LA; i++) begin
            for (int j = 0; j < LB; j++) begin
                prod[i*LB+j]   = a_limb[i] * b_limb[j];
                prod_x[i*LB+j] = XW'(prod[i*LB+j]) <<< (LIMB_W * (i + j));
            end
        end
        for (int k = 0; k < NPP; k++) begin
            leaf[k] = '0;
        end
        for (int k = 0; k < NP; k++) begin
            leaf[k] = prod_x[k][PW-1:0];
        end
    end

    // heap-ordered tree: leaves at NPP-1.., root at 0
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NPP; k++) begin
                node_reg[NPP-1+k] <= leaf[k];
            end
            for (int j = 0; j < NPP - 1; j++) begin
                node_reg[j] <= node_reg[2*j+1] + node_reg[2*j+2];
            end
        end
    end

    assign p = node_reg[0];

endmodule

[rtl/signed_dihedral_angle.sv]
// ============================================================================
// signed_dihedral_angle - signed dihedral angle of three Q16.16 vectors
// Normals n1 = c x b and n2 = a x b, angle atan2(|n1 x n2|, n1.n2) by CORDIC,
// mirrored to 2pi - angle when (n1 x n2).b > 0. Result unsigned Q3.29.
// ============================================================================
// Usage:
//   Input channel s_*: one transfer carries a, b, c (nine signed
//   COORD_WIDTH-bit coordinates). Result channel m_*: one transfer per input
//   carrying m_angle in radians, unsigned Q3.29 (0 .. 2pi).
//   Throughput: one item per cycle, sustained, while m_ready stays high.
//   The depth is set by the exact wide cross products (limb multipliers
//   with adder trees), a 30-stage square root and 30 CORDIC stages.
//   Stall: the whole pipeline advances on one enable. A result that meets a
//   stalled receiver parks in a skid register; only while that register is
//   full does s_ready drop, so items keep entering until a result parks there.
//   Nothing is lost or repeated across a stall.
//   Reset (aresetn low, synchronous): clears all valid bits, among them the
//   output and skid valid bits. Items in flight are dropped. Nothing is kept
//   between items, so no state needs clearing otherwise.
// ============================================================================
module signed_dihedral_angle
    import sda_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_WIDTH-1:0] s_a_x,
    input  logic signed [COORD_WIDTH-1:0] s_a_y,
    input  logic signed [COORD_WIDTH-1:0] s_a_z,
    input  logic signed [COORD_WIDTH-1:0] s_b_x,
    input  logic signed [COORD_WIDTH-1:0] s_b_y,
    input  logic signed [COORD_WIDTH-1:0] s_b_z,
    input  logic signed [COORD_WIDTH-1:0] s_c_x,
    input  logic signed [COORD_WIDTH-1:0] s_c_y,
    input  logic signed [COORD_WIDTH-1:0] s_c_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ANG_W-1:0]              m_angle
);

    // ------------------------------------------------------------------
    // Widths and stage bookkeeping
    // ------------------------------------------------------------------
    localparam int W     = COORD_WIDTH;
    localparam int NW    = 2 * W + 1;      // normal components
    localparam int WW    = 4 * W + 3;      // n1 x n2 components
    localparam int DW    = 4 * W + 4;      // n1 . n2
    localparam int SW    = 5 * W + 5;      // (n1 x n2) . b
    localparam int L1    = mul_latency(W, W);
    localparam int L2    = mul_latency(NW, NW);
    localparam int L3    = mul_latency(WW, W);
    localparam int T2    = L1 + L2 + 2;    // pipeline depth up to the w/d registers
    localparam int NCH   = (DW + LIMB_W - 1) / LIMB_W;
    localparam int MPW   = NCH * LIMB_W;
    localparam int KW    = $clog2(DW + 1);
    localparam int ISQ_N = SH_W;
    localparam int RAD_W = 2 * SH_W;
    localparam int CW    = SH_W + 4;
    localparam int ZW    = ANG_W + 2;
    localparam int FD    = 6 + ISQ_N + CORDIC_STEPS - L3;
    localparam int TOT   = T2 + 8 + ISQ_N + CORDIC_STEPS;

    localparam int NEXT1 [3] = '{1, 2, 0};
    localparam int NEXT2 [3] = '{2, 0, 1};

    localparam logic signed [ZW-1:0] Z_PI      = ZW'(ANG_PI);
    localparam logic signed [ZW-1:0] Z_HALF_PI = ZW'(ANG_HALF_PI);

    // ------------------------------------------------------------------
    // Flow control: one enable for the whole pipe, skid at the output
    // ------------------------------------------------------------------
    logic             en;
    logic [TOT-1:0]   vld_reg;
    logic             m_valid_reg;
    logic [ANG_W-1:0] m_angle_reg;
    logic             skid_vld_reg;
    logic [ANG_W-1:0] skid_angle_reg;
    logic [ANG_W-1:0] res_reg;
    logic             out_free;

    assign en       = !skid_vld_reg;
    assign s_ready  = en;
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_valid_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            if (en) begin
                vld_reg <= {vld_reg[TOT-2:0], s_valid};
            end
            priority if (skid_vld_reg) begin
                if (out_free) begin
                    m_valid_reg  <= 1'b1;
                    skid_vld_reg <= 1'b0;
                end
            end else if (vld_reg[TOT-1]) begin
                // tail leaves the pipe this cycle
                if (out_free) begin
                    m_valid_reg <= 1'b1;
                end else begin
                    skid_vld_reg <= 1'b1;
                end
            end else if (out_free) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_vld_reg) begin
            if (out_free) begin
                m_angle_reg <= skid_angle_reg;
            end
        end else if (vld_reg[TOT-1]) begin
            if (out_free) begin
                m_angle_reg <= res_reg;
            end else begin
                skid_angle_reg <= res_reg;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_angle = m_angle_reg;

    // ------------------------------------------------------------------
    // Stage group 1: n1 = c x b, n2 = a x b (twelve W x W products)
    // ------------------------------------------------------------------
    logic signed [W-1:0]    in_b  [3];
    logic signed [W-1:0]    in_v  [2][3];   // [0] = c, [1] = a
    logic signed [W-1:0]    g1_opa  [12];
    logic signed [W-1:0]    g1_opb  [12];
    logic signed [2*W-1:0]  g1_prod [12];
    logic signed [NW-1:0]   n_reg [2][3];

    assign in_b[0]    = s_b_x;
    assign in_b[1]    = s_b_y;
    assign in_b[2]    = s_b_z;
    assign in_v[0][0] = s_c_x;
    assign in_v[0][1] = s_c_y;
    assign in_v[0][2] = s_c_z;
    assign in_v[1][0] = s_a_x;
    assign in_v[1][1] = s_a_y;
    assign in_v[1][2] = s_a_z;

    always_comb begin
        for (int v = 0; v < 2; v++) begin
            for (int r = 0; r < 3; r++) begin
                g1_opa[6*v+2*r]   = in_v[v][NEXT1[r]];
                g1_opb[6*v+2*r]   = in_b[NEXT2[r]];
                g1_opa[6*v+2*r+1] = in_v[v][NEXT2[r]];
                g1_opb[6*v+2*r+1] = in_b[NEXT1[r]];
            end
        end
    end

    for (genvar g = 0; g < 12; g++) begin : g_mul1
        sda_mul #(.AW(W), .BW(W)) u_mul (
            .aclk (aclk),
            .en   (en),
            .a    (g1_opa[g]),
            .b    (g1_opb[g]),
            .p    (g1_prod[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int v = 0; v < 2; v++) begin
                for (int r = 0; r < 3; r++) begin
                    n_reg[v][r] <= NW'(g1_prod[6*v+2*r]) - NW'(g1_prod[6*v+2*r+1]);
                end
            end
        end
    end

    // b rides alongside until the final dot product
    logic signed [W-1:0] b_dly_reg [T2][3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                b_dly_reg[0][r] <= in_b[r];
            end
            for (int k = 1; k < T2; k++) begin
                b_dly_reg[k] <= b_dly_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage group 2: w = n1 x n2 and d = n1 . n2 (exact)
    // ------------------------------------------------------------------
    logic signed [NW-1:0]   g2_opa  [9];
    logic signed [NW-1:0]   g2_opb  [9];
    logic signed [2*NW-1:0] g2_prod [9];
    logic signed [WW-1:0]   w_reg [3];
    logic signed [DW-1:0]   d_reg;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            g2_opa[2*r]   = n_reg[0][NEXT1[r]];
            g2_opb[2*r]   = n_reg[1][NEXT2[r]];
            g2_opa[2*r+1] = n_reg[0][NEXT2[r]];
            g2_opb[2*r+1] = n_reg[1][NEXT1[r]];
            g2_opa[6+r]   = n_reg[0][r];
            g2_opb[6+r]   = n_reg[1][r];
        end
    end

    for (genvar g = 0; g < 9; g++) begin : g_mul2
        sda_mul #(.AW(NW), .BW(NW)) u_mul (
            .aclk (aclk),
            .en   (en),
            .a    (g2_opa[g]),
            .b    (g2_opb[g]),
            .p    (g2_prod[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                w_reg[r] <= WW'(g2_prod[2*r]) - WW'(g2_prod[2*r+1]);
            end
            d_reg <= DW'(g2_prod[6]) + DW'(g2_prod[7]) + DW'(g2_prod[8]);
        end
    end

    // ------------------------------------------------------------------
    // Stage group 3: orientation s = w . b, flip when s > 0
    // ------------------------------------------------------------------
    logic signed [WW+W-1:0] g3_prod [3];
    logic signed [SW-1:0]   s_sum;
    logic                   fp_reg [FD+1];

    for (genvar g = 0; g < 3; g++) begin : g_mul3
        sda_mul #(.AW(WW), .BW(W)) u_mul (
            .aclk (aclk),
            .en   (en),
            .a    (w_reg[g]),
            .b    (b_dly_reg[T2-1][g]),
            .p    (g3_prod[g])
        );
    end

    assign s_sum = SW'(g3_prod[0]) + SW'(g3_prod[1]) + SW'(g3_prod[2]);

    always_ff @(posedge aclk) begin
        if (en) begin
            fp_reg[0] <= (s_sum > 0);
            for (int k = 1; k <= FD; k++) begin
                fp_reg[k] <= fp_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Normalize: common bit length of w and d, shift all four so that
    // they fit in [-2^29, 2^29)
    // ------------------------------------------------------------------
    logic [DW-1:0]         mag_or;
    logic [MPW-1:0]        mag_pad;
    logic [5:0]            ch_len_reg [NCH];
    logic signed [DW-1:0]  nv1_reg [4];
    logic [KW-1:0]         lbits;
    logic [KW-1:0]         k_reg;
    logic signed [DW-1:0]  nv2_reg [4];
    logic [4:0]            kf_reg;
    logic signed [DW-1:0]  nv3_reg [4];
    logic signed [DW-1:0]  nv_fine [4];
    logic signed [SH_W-1:0] sh_reg [4];   // [0..2] = w, [3] = d

    always_comb begin
        mag_or = d_reg ^ {DW{d_reg[DW-1]}};
        for (int r = 0; r < 3; r++) begin
            mag_or = mag_or | DW'(w_reg[r] ^ {WW{w_reg[r][WW-1]}});
        end
        mag_pad = MPW'(mag_or);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < NCH; c++) begin
                ch_len_reg[c] <= bit_len32(mag_pad[c*LIMB_W +: LIMB_W]);
            end
            for (int r = 0; r < 3; r++) begin
                nv1_reg[r] <= DW'(w_reg[r]);
            end
            nv1_reg[3] <= d_reg;
        end
    end

    always_comb begin
        lbits = '0;
        for (int c = 0; c < NCH; c++) begin
            if (ch_len_reg[c] != '0) begin
                lbits = KW'(c * LIMB_W) + KW'(ch_len_reg[c]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k_reg   <= (lbits > KW'(FRAC_BITS)) ? lbits - KW'(FRAC_BITS) : '0;
            nv2_reg <= nv1_reg;
            // coarse shift by whole limbs, then the remainder
            for (int i = 0; i < 4; i++) begin
                nv3_reg[i] <= nv2_reg[i] >>> (k_reg & ~KW'(LIMB_W - 1));
            end
            kf_reg <= k_reg[4:0];
            for (int i = 0; i < 4; i++) begin
                sh_reg[i] <= nv_fine[i][SH_W-1:0];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            nv_fine[i] = nv3_reg[i] >>> kf_reg;
        end
    end

    // ------------------------------------------------------------------
    // |w|^2 and integer square root (one bit pair per stage)
    // ------------------------------------------------------------------
    logic signed [RAD_W-1:0] sq_c [3];
    logic [RAD_W-1:0]        sq_reg [3];
    logic signed [SH_W-1:0]  x1_reg;
    logic [RAD_W-1:0]        rad_reg;
    logic signed [SH_W-1:0]  x2_reg;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            sq_c[r] = sh_reg[r] * sh_reg[r];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 3; r++) begin
                sq_reg[r] <= sq_c[r];
            end
            x1_reg  <= sh_reg[3];
            rad_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            x2_reg  <= x1_reg;
        end
    end

    logic [RAD_W-1:0]       isq_rem_reg  [ISQ_N];
    logic [RAD_W-1:0]       isq_res_reg  [ISQ_N];
    logic signed [SH_W-1:0] isq_x_reg    [ISQ_N];
    logic [RAD_W-1:0]       isq_rem_in   [ISQ_N];
    logic [RAD_W-1:0]       isq_res_in   [ISQ_N];
    logic signed [SH_W-1:0] isq_x_in     [ISQ_N];
    logic [RAD_W:0]         isq_bit      [ISQ_N];
    logic [RAD_W:0]         isq_trial    [ISQ_N];
    logic [RAD_W-1:0]       isq_rem_next [ISQ_N];
    logic [RAD_W-1:0]       isq_res_next [ISQ_N];

    always_comb begin
        isq_rem_in[0] = rad_reg;
        isq_res_in[0] = '0;
        isq_x_in[0]   = x2_reg;
        for (int j = 1; j < ISQ_N; j++) begin
            isq_rem_in[j] = isq_rem_reg[j-1];
            isq_res_in[j] = isq_res_reg[j-1];
            isq_x_in[j]   = isq_x_reg[j-1];
        end
        for (int j = 0; j < ISQ_N; j++) begin
            isq_bit[j]   = (RAD_W + 1)'(1) << (2 * (ISQ_N - 1 - j));
            isq_trial[j] = {1'b0, isq_res_in[j]} + isq_bit[j];
            if ({1'b0, isq_rem_in[j]} >= isq_trial[j]) begin
                isq_rem_next[j] = isq_rem_in[j] - isq_trial[j][RAD_W-1:0];
                isq_res_next[j] = (isq_res_in[j] >> 1) + isq_bit[j][RAD_W-1:0];
            end else begin
                isq_rem_next[j] = isq_rem_in[j];
                isq_res_next[j] = isq_res_in[j] >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            isq_rem_reg <= isq_rem_next;
            isq_res_reg <= isq_res_next;
            isq_x_reg   <= isq_x_in;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC vectoring: quadrant pre-rotation, then one step per stage
    // ------------------------------------------------------------------
    logic [SH_W:0]          y_root;
    logic signed [SH_W-1:0] x_root;
    logic signed [CW-1:0]   cr_x_reg [CORDIC_STEPS+1];
    logic signed [CW-1:0]   cr_y_reg [CORDIC_STEPS+1];
    logic signed [ZW-1:0]   cr_z_reg [CORDIC_STEPS+1];
    logic                   cr_zero_reg [CORDIC_STEPS+1];
    logic                   cr_xneg_reg [CORDIC_STEPS+1];
    logic signed [CW-1:0]   cr_dx [CORDIC_STEPS];
    logic signed [CW-1:0]   cr_dy [CORDIC_STEPS];
    logic signed [CW-1:0]   cr_x_next [CORDIC_STEPS];
    logic signed [CW-1:0]   cr_y_next [CORDIC_STEPS];
    logic signed [ZW-1:0]   cr_z_next [CORDIC_STEPS];

    assign y_root = isq_res_reg[ISQ_N-1][SH_W:0];
    assign x_root = isq_x_reg[ISQ_N-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            cr_zero_reg[0] <= (y_root == '0);
            cr_xneg_reg[0] <= (x_root < 0);
            if (x_root < 0) begin
                // turn by -pi/2: (x, y) -> (y, -x)
                cr_x_reg[0] <= CW'(y_root);
                cr_y_reg[0] <= -CW'(x_root);
                cr_z_reg[0] <= Z_HALF_PI;
            end else begin
                cr_x_reg[0] <= CW'(x_root);
                cr_y_reg[0] <= CW'(y_root);
                cr_z_reg[0] <= '0;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            cr_dx[i] = cr_x_reg[i] >>> i;
            cr_dy[i] = cr_y_reg[i] >>> i;
            if (cr_y_reg[i] > 0) begin
                cr_x_next[i] = cr_x_reg[i] + cr_dy[i];
                cr_y_next[i] = cr_y_reg[i] - cr_dx[i];
                cr_z_next[i] = cr_z_reg[i] + ZW'(atan_entry(i));
            end else if (cr_y_reg[i] < 0) begin
                cr_x_next[i] = cr_x_reg[i] - cr_dy[i];
                cr_y_next[i] = cr_y_reg[i] + cr_dx[i];
                cr_z_next[i] = cr_z_reg[i] - ZW'(atan_entry(i));
            end else begin
                cr_x_next[i] = cr_x_reg[i];
                cr_y_next[i] = cr_y_reg[i];
                cr_z_next[i] = cr_z_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                cr_x_reg[i+1]    <= cr_x_next[i];
                cr_y_reg[i+1]    <= cr_y_next[i];
                cr_z_reg[i+1]    <= cr_z_next[i];
                cr_zero_reg[i+1] <= cr_zero_reg[i];
                cr_xneg_reg[i+1] <= cr_xneg_reg[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Clamp to 0..pi, parallel-normal case, orientation mirror
    // ------------------------------------------------------------------
    logic signed [ZW-1:0] z_fin;
    logic [ANG_W-1:0]     z_clamp;

    assign z_fin = cr_z_reg[CORDIC_STEPS];

    always_comb begin
        priority if (cr_zero_reg[CORDIC_STEPS]) begin
            z_clamp = cr_xneg_reg[CORDIC_STEPS] ? ANG_PI : '0;
        end else if (z_fin < 0) begin
            z_clamp = '0;
        end else if (z_fin > Z_PI) begin
            z_clamp = ANG_PI;
        end else begin
            z_clamp = z_fin[ANG_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= fp_reg[FD] ? ANG_TWO_PI - z_clamp : z_clamp;
        end
    end

endmodule

[rtl/sda_checker.sv]
// ============================================================================
// sda_checker - port-level checks for signed_dihedral_angle
// Output hold under stall, angle range, reset behavior and back-pressure.
// ============================================================================
module sda_checker
    import sda_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_ready,
    input logic             m_valid,
    input logic             m_ready,
    input logic [ANG_W-1:0] m_angle
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_angle))
        else $error("m_angle changed or dropped while stalled");

    // angle never beyond 2pi
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_angle <= ANG_TWO_PI)
        else $error("m_angle out of range");

    // reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // input side only backs off behind a held result
    a_bp_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(m_valid && !m_ready))
        else $error("s_ready fell without an output stall");

    a_bp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("s_ready low with empty output");

endmodule

bind signed_dihedral_angle sda_checker u_sda_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_angle (m_angle)
);

[sim/signed_dihedral_angle_tb.sv]
// ----------------------------------------------------------------------------
// signed_dihedral_angle_tb - self-checking bench for the dihedral angle block
// Streams directed and random vector triples through the block with random
// idle cycles on both sides and one long receiver hold-off. Each angle is
// predicted with exact wide integer geometry plus a bit-true CORDIC and
// compared in transfer order.
// ----------------------------------------------------------------------------
module signed_dihedral_angle_tb
    import sda_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W         = 32;
    localparam int N_RANDOM  = 1530;
    localparam int LATENCY   = 79 + 68;
    localparam int MAX_CYCLES = 400000;

    typedef logic signed [255:0] wide_t;

    // one input item: a, b, c in that order, x/y/z each
    typedef struct packed {
        logic signed [W-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    } triple_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [W-1:0] s_a_x = '0, s_a_y = '0, s_a_z = '0;
    logic signed [W-1:0] s_b_x = '0, s_b_y = '0, s_b_z = '0;
    logic signed [W-1:0] s_c_x = '0, s_c_y = '0, s_c_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [ANG_W-1:0] m_angle;

    triple_t pending_triples[$];
    logic [ANG_W-1:0] expected_angles[$];
    int errors = 0;
    int checked = 0;
    int cycle_count = 0;
    bit stim_done = 1'b0;
    bit hold_request = 1'b0;  // asks the receiver for one long stall

    signed_dihedral_angle #(.COORD_WIDTH(W)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_a_x(s_a_x), .s_a_y(s_a_y), .s_a_z(s_a_z),
        .s_b_x(s_b_x), .s_b_y(s_b_y), .s_b_z(s_b_z),
        .s_c_x(s_c_x), .s_c_y(s_c_y), .s_c_z(s_c_z),
        .m_valid(m_valid), .m_ready(m_ready), .m_angle(m_angle)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Angle predictor
    // ------------------------------------------------------------------------
    // Bits needed so that v lies in [-2^L, 2^L)
    function automatic int span_bits(input wide_t v);
        logic [255:0] m;
        int n;
        m = v[255] ? ~v : v;
        n = 0;
        for (int i = 0; i < 256; i++) begin
            if (m[i]) begin
                n = i + 1;
            end
        end
        return n;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [ANG_W-1:0] predict_angle(input triple_t t);
        wide_t a[3], b[3], c[3], n1[3], n2[3], wv[3], dp, sp, sh[4];
        longint sx, sy, sz, tmp, dx, dy;
        logic [63:0] sum;
        int lmax, k;
        bit mirror;
        logic [ANG_W-1:0] z32;
        a[0] = t.ax; a[1] = t.ay; a[2] = t.az;
        b[0] = t.bx; b[1] = t.by; b[2] = t.bz;
        c[0] = t.cx; c[1] = t.cy; c[2] = t.cz;
        // plane normals and their cross/dot products, exact
        n1[0] = c[1]*b[2] - c[2]*b[1];
        n1[1] = c[2]*b[0] - c[0]*b[2];
        n1[2] = c[0]*b[1] - c[1]*b[0];
        n2[0] = a[1]*b[2] - a[2]*b[1];
        n2[1] = a[2]*b[0] - a[0]*b[2];
        n2[2] = a[0]*b[1] - a[1]*b[0];
        wv[0] = n1[1]*n2[2] - n1[2]*n2[1];
        wv[1] = n1[2]*n2[0] - n1[0]*n2[2];
        wv[2] = n1[0]*n2[1] - n1[1]*n2[0];
        dp = n1[0]*n2[0] + n1[1]*n2[1] + n1[2]*n2[2];
        sp = wv[0]*b[0] + wv[1]*b[1] + wv[2]*b[2];
        mirror = (sp > 0);
        // normalize so every term fits in 30 signed bits
        lmax = span_bits(dp);
        for (int i = 0; i < 3; i++) begin
            if (span_bits(wv[i]) > lmax) lmax = span_bits(wv[i]);
        end
        k = (lmax > FRAC_BITS) ? lmax - FRAC_BITS : 0;
        for (int i = 0; i < 3; i++) sh[i] = wv[i] >>> k;
        sh[3] = dp >>> k;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            sum += 64'(sh[i][63:0] * sh[i][63:0]);
        end
        sy = longint'(int_sqrt(sum));
        sx = longint'(sh[3][63:0]);
        if (sy == 0) begin
            sz = (sx < 0) ? longint'(ANG_PI) : 0;
        end else begin
            sz = 0;
            if (sx < 0) begin
                // pre-rotate by -pi/2
                tmp = sx; sx = sy; sy = -tmp; sz = longint'(ANG_HALF_PI);
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = sx >>> i;
                dy = sy >>> i;
                if (sy > 0) begin
                    sx += dy; sy -= dx; sz += longint'(atan_entry(i));
                end else if (sy < 0) begin
                    sx -= dy; sy += dx; sz -= longint'(atan_entry(i));
                end
            end
            if (sz < 0) sz = 0;
            if (sz > longint'(ANG_PI)) sz = longint'(ANG_PI);
        end
        z32 = ANG_W'(sz);
        return mirror ? ANG_TWO_PI - z32 : z32;
    endfunction

    function automatic logic [W-1:0] rand_coord();
        // mix full-range, small, extreme and sign-edge values
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2: return W'($signed($urandom_range(0, 8)) - 4);
            3: return W'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        triple_t t;
        logic signed [W-1:0] mx, mn;
        mx = 32'sh7FFF_FFFF;
        mn = 32'sh8000_0000;
        // all zero: zero normals
        pending_triples.push_back('0);
        // zero axis
        pending_triples.push_back({32'sd5, 32'sd7, -32'sd3, 96'd0, 32'sd1, 32'sd2, 32'sd3});
        // coplanar a and c on same side: parallel normals, angle 0
        pending_triples.push_back({32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd65536,
                                   32'sd131072, 32'sd0, 32'sd0});
        // opposite sides: angle pi
        pending_triples.push_back({32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd65536,
                                   -32'sd65536, 32'sd0, 32'sd0});
        // quarter turns both ways, to hit the mirrored result
        pending_triples.push_back({32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd65536,
                                   32'sd0, 32'sd65536, 32'sd0});
        pending_triples.push_back({32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd65536,
                                   32'sd0, -32'sd65536, 32'sd0});
        // obtuse case, negative dot
        pending_triples.push_back({32'sd3, 32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd1,
                                   -32'sd2, 32'sd1, 32'sd0});
        // extremes of every field
        pending_triples.push_back({9{mx}});
        pending_triples.push_back({9{mn}});
        pending_triples.push_back({mx, mn, mx, mn, mx, mn, mx, mn, mx});
        pending_triples.push_back({mn, mx, 32'sd0, 32'sd0, mn, mx, mx, 32'sd0, mn});
        pending_triples.push_back({mx, 32'sd0, 32'sd0, 32'sd0, 32'sd0, mn, 32'sd0, mx, 32'sd0});
        pending_triples.push_back({mn, 32'sd0, 32'sd0, 32'sd0, 32'sd0, mx, 32'sd0, mn, 32'sd0});
        pending_triples.push_back({-32'sd1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, -32'sd1,
                                   32'sd0, 32'sd1, 32'sd0});
        for (int i = 0; i < N_RANDOM; i++) begin
            t.ax = rand_coord(); t.ay = rand_coord(); t.az = rand_coord();
            t.bx = rand_coord(); t.by = rand_coord(); t.bz = rand_coord();
            t.cx = rand_coord(); t.cy = rand_coord(); t.cz = rand_coord();
            // sometimes force a plane setup: c in the a-b plane or zero axis
            case ($urandom_range(0, 15))
                0: begin t.cx = t.ax; t.cy = t.ay; t.cz = t.az; end
                1: begin t.cx = -t.ax; t.cy = -t.ay; t.cz = -t.az; end
                2: begin t.bx = '0; t.by = '0; t.bz = '0; end
                default: ;
            endcase
            pending_triples.push_back(t);
        end
    end

    // reset, then kick the long receiver stall once traffic is flowing
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (400) @(posedge aclk);
        hold_request = 1'b1;
    end

    // ------------------------------------------------------------------------
    // Driver: one transfer per accepted item, random gaps of idle cycles
    // ------------------------------------------------------------------------
    int send_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_angles.push_back(predict_angle({s_a_x, s_a_y, s_a_z,
                    s_b_x, s_b_y, s_b_z, s_c_x, s_c_y, s_c_z}));
            end
            if (!s_valid || s_ready) begin
                // current transfer done (or none): pick next
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid <= 1'b0;
                end else if (pending_triples.size() > 0) begin
                    triple_t t;
                    t = pending_triples.pop_front();
                    {s_a_x, s_a_y, s_a_z, s_b_x, s_b_y, s_b_z, s_c_x, s_c_y, s_c_z} <= t;
                    s_valid <= 1'b1;
                    // stretches of back-to-back traffic now and then
                    send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0;
                end else begin
                    s_valid <= 1'b0;
                    stim_done <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: random ready, one long hold-off, compare in order
    // ------------------------------------------------------------------------
    int hold_cycles = 0;
    int recv_gap = 0;
    bit hold_done = 1'b0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_angles.size() == 0) begin
                    $display("%0t: unexpected result, actual %0d", $time, m_angle);
                    errors++;
                end else begin
                    logic [ANG_W-1:0] want;
                    want = expected_angles.pop_front();
                    if (want !== m_angle) begin
                        $display("%0t: angle mismatch, expected %0d actual %0d",
                                 $time, want, m_angle);
                        errors++;
                    end
                    checked++;
                end
            end
            if (hold_request && !hold_done) begin
                // long stall so the pipeline backs up and s_ready drops
                m_ready <= 1'b0;
                hold_cycles <= hold_cycles + 1;
                if (hold_cycles >= 3 * LATENCY) hold_done <= 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (m_valid && m_ready) begin
                    recv_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 10) : 0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // End of run and timeout
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, expected_angles.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        wait (stim_done && expected_angles.size() == 0);
        repeat (LATENCY + 20) @(posedge aclk);
        $display("covered %0d angle results incl. zero-normal, parallel, mirrored",
                 checked);
        $display("and extreme-coordinate cases, with both-side stalls and a long hold-off");
        if (errors == 0 && expected_angles.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
